// ===== design/fsba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator package
// Shared constants and types of the fit search block allocator.
// ----------------------------------------------------------------------------
package fsba_pkg;
    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEAP_BYTES_DEF   = 65536;
    localparam int WORD_BYTES_DEF   = 8;
    localparam int HEADER_BYTES_DEF = 24;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_NEXT  = 2'd1;
    localparam logic [1:0] MODE_BEST  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    // One table entry: used mark, size, data start.
    localparam int ENTRY_W = 33;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DEC   = 7'b0000100,
        S_SHIFT = 7'b0001000,
        S_SHW   = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;
endpackage
`default_nettype wire

// ===== design/fit_search_block_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fit search block allocator
// Table based heap allocator with first, next and best fit search.
// ----------------------------------------------------------------------------
// The block keeps an address-ordered table of heap blocks in one RAM and
// serves one item at a time; s_ready is low while an item is at work and
// while a result waits to be taken. A free or an allocate walks the table
// through the RAM read port, issuing the read of an entry and then
// comparing the registered read data. A first or next fit search or a
// free stops at a hit; a best fit search visits every entry. An allocate
// that splits a block moves every entry above the split point up one
// place. A heap reset item and an unused opcode skip the table walk. The
// result waits in an output register until it is taken. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module fit_search_block_allocator
    import fsba_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int WORD_BYTES   = WORD_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [15:0] s_request_bytes,
    input  wire logic [15:0] s_address,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [15:0]      m_data_address,
    output logic [15:0]      m_granted_bytes,
    output logic             m_reused
);
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
    localparam logic [IW-1:0] MAXI1 = IW'(MAX_BLOCKS - 1);

    state_t state_reg, state_next;
    logic [1:0]    mode_reg;
    logic [1:0]    op_reg;
    logic [16:0]   need_reg;
    logic [15:0]   addr_reg;
    logic [CW-1:0] count_reg;
    logic [24:0]   top_reg;
    logic [IW-1:0] nstart_reg;
    logic [CW-1:0] step_reg;   // entries visited
    logic [IW-1:0] idx_reg;    // entry being read
    logic          pend_reg;   // read data valid
    logic          found_reg;
    logic [IW-1:0] fidx_reg;
    logic [15:0]   fsize_reg;
    logic [15:0]   fstart_reg;
    logic [IW-1:0] mv_reg;     // shift source index
    logic [ENTRY_W-1:0] hold_reg;

    logic               we;
    logic [IW-1:0]      waddr, raddr;
    logic [ENTRY_W-1:0] wdata, rdata;

    fsba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    wire        r_used  = rdata[32];
    wire [15:0] r_size  = rdata[31:16];
    wire [15:0] r_start = rdata[15:0];

    // Next entry index in the scan order, wrapping at block_count.
    logic [IW-1:0] idx_inc;
    always_comb begin
        idx_inc = idx_reg + IW'(1);
        if (CW'(idx_inc) == count_reg || idx_reg == MAXI1) begin
            idx_inc = '0;
        end
    end

    wire fits = !r_used && ({1'b0, r_size} >= need_reg);
    wire [16:0] rem = {1'b0, fsize_reg} - need_reg;
    wire split_ok = (rem >= 17'(HEADER_BYTES + WORD_BYTES)) && (count_reg < MAXC);
    wire [IW-1:0] ins = fidx_reg + IW'(1);
    wire [25:0] gdata = {1'b0, top_reg} + 26'(HEADER_BYTES);
    wire [26:0] gend  = {1'b0, gdata} + 27'(need_reg);
    // A new block can be appended at the heap top.
    wire append_ok = !need_reg[16] && (count_reg < MAXC) && (gdata <= 26'hFFFF) &&
                     (gend <= 27'(HEAP_BYTES));

    // Result fields of the item at work.
    logic [1:0]  res_status;
    logic [15:0] res_addr;
    logic [15:0] res_granted;
    logic        res_reused;
    always_comb begin
        res_status  = ST_OK;
        res_addr    = '0;
        res_granted = '0;
        res_reused  = 1'b0;
        case (op_reg)
            OP_FREE: begin
                if (!found_reg) res_status = ST_UNKNOWN;
            end
            OP_ALLOC: begin
                if (found_reg) begin
                    res_addr    = fstart_reg;
                    res_granted = hold_reg[31:16];
                    res_reused  = 1'b1;
                end else if (append_ok) begin
                    res_addr    = 16'(gdata);
                    res_granted = 16'(need_reg);
                end else begin
                    res_status  = ST_NOMEM;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == S_IDLE) && !m_valid;
        state_next = state_reg;
        we    = 1'b0;
        waddr = idx_reg;
        wdata = '0;
        raddr = idx_reg;
        case (state_reg)
            S_IDLE:  begin
                if (s_valid && s_ready)
                    state_next = (s_opcode == OP_ALLOC || s_opcode == OP_FREE) ?
                                 S_SCAN : S_OUT;
            end
            S_SCAN:  begin
                if (!pend_reg && step_reg == count_reg) state_next = S_DEC;
                if (pend_reg && op_reg == OP_FREE && r_start == addr_reg)
                    state_next = S_DEC;
                if (pend_reg && op_reg == OP_ALLOC && fits && mode_reg != MODE_BEST)
                    state_next = S_DEC;
            end
            S_DEC:   begin
                state_next = (op_reg == OP_ALLOC && found_reg && split_ok &&
                              CW'(ins) < count_reg) ? S_SHIFT : S_FIN;
            end
            S_SHIFT: begin raddr = mv_reg; state_next = S_SHW; end
            S_SHW:   begin
                we = 1'b1; waddr = mv_reg + IW'(1); wdata = rdata;
                state_next = (mv_reg == ins) ? S_FIN : S_SHIFT;
            end
            S_FIN:   state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        // A found entry is written back; a failed allocate appends at block_count if it fits.
        if (state_reg == S_FIN && (found_reg || (op_reg == OP_ALLOC && append_ok))) begin
            we    = 1'b1;
            waddr = found_reg ? fidx_reg : IW'(count_reg);
            wdata = found_reg ? hold_reg : {1'b1, 16'(need_reg), 16'(gdata)};
        end
        if (state_reg == S_OUT && op_reg == OP_ALLOC && found_reg && split_ok) begin
            we = 1'b1; waddr = ins;
            wdata = {1'b0, 16'(rem - 17'(HEADER_BYTES)),
                     16'({1'b0, fstart_reg} + need_reg + 17'(HEADER_BYTES))};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mode_reg   <= MODE_FIRST;
            count_reg  <= '0;
            top_reg    <= '0;
            nstart_reg <= '0;
            m_valid    <= 1'b0;
            pend_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) mode_reg <= cfg_wdata;
            m_valid <= (state_reg == S_OUT) || (m_valid && !m_ready);
            case (state_reg)
                S_IDLE: if (s_valid && s_ready) begin
                    op_reg    <= s_opcode;
                    addr_reg  <= s_address;
                    need_reg  <= (17'(s_request_bytes) + 17'(WORD_BYTES - 1))
                                 / 17'(WORD_BYTES) * 17'(WORD_BYTES);
                    found_reg <= 1'b0;
                    step_reg  <= '0;
                    pend_reg  <= 1'b0;
                    idx_reg   <= (s_opcode == OP_ALLOC && mode_reg == MODE_NEXT &&
                                  CW'(nstart_reg) < count_reg) ? nstart_reg : '0;
                end
                S_SCAN: begin
                    pend_reg <= !pend_reg && step_reg != count_reg;
                    if (!pend_reg && step_reg != count_reg) begin
                        step_reg <= step_reg + CW'(1);
                    end
                    if (pend_reg) begin
                        if (op_reg == OP_FREE && r_start == addr_reg) begin
                            found_reg <= 1'b1; fidx_reg <= idx_reg;
                            hold_reg  <= {1'b0, r_size, r_start};
                        end else if (op_reg == OP_ALLOC && fits &&
                                     (!found_reg || mode_reg != MODE_BEST ||
                                      r_size < fsize_reg)) begin
                            found_reg  <= 1'b1; fidx_reg <= idx_reg;
                            fsize_reg  <= r_size; fstart_reg <= r_start;
                        end
                        idx_reg <= idx_inc;
                    end
                end
                S_DEC: begin
                    mv_reg <= IW'(count_reg - CW'(1));
                    if (op_reg == OP_ALLOC && found_reg) begin
                        hold_reg <= {1'b1, split_ok ? 16'(need_reg) : fsize_reg, fstart_reg};
                        if (mode_reg == MODE_NEXT) nstart_reg <= fidx_reg;
                    end
                end
                S_SHW: mv_reg <= mv_reg - IW'(1);
                S_FIN: ;
                S_OUT: begin
                    m_status        <= res_status;
                    m_data_address  <= res_addr;
                    m_granted_bytes <= res_granted;
                    m_reused        <= res_reused;
                    if (op_reg == OP_CLEAR) begin
                        count_reg <= '0; top_reg <= '0; nstart_reg <= '0;
                    end else if (op_reg == OP_ALLOC && found_reg) begin
                        if (split_ok) begin
                            count_reg <= count_reg + CW'(1);
                            if (mode_reg == MODE_NEXT) begin
                                if (ins <= fidx_reg && fidx_reg < MAXI1)
                                    nstart_reg <= fidx_reg + IW'(1);
                            end else if (ins <= nstart_reg && nstart_reg < MAXI1) begin
                                nstart_reg <= nstart_reg + IW'(1);
                            end
                        end
                    end else if (op_reg == OP_ALLOC && append_ok) begin
                        count_reg <= count_reg + CW'(1);
                        top_reg   <= 25'(gend);
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/fsba_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module fsba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
